// ----- rtl/msw_pkg.sv -----
`default_nettype none

package msw_pkg;

  // pending whitespace queue
  localparam int unsigned PendDepth = 16;
  localparam int unsigned PtrW      = (PendDepth > 1) ? $clog2(PendDepth) : 1;
  localparam int unsigned CntW      = $clog2(PendDepth + 1);

  // character codes
  localparam logic [7:0] ChLt  = 8'h3C;
  localparam logic [7:0] ChGt  = 8'h3E;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;

  // queued whitespace codes
  localparam logic [1:0] WsSp  = 2'd0;
  localparam logic [1:0] WsTab = 2'd1;
  localparam logic [1:0] WsLf  = 2'd2;
  localparam logic [1:0] WsCr  = 2'd3;

  // what the collapse stage hands to trim
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WS,
    KIND_CHAR
  } kind_e;

  // source of an output beat
  typedef enum logic [1:0] {
    EMIT_POP,
    EMIT_CHAR,
    EMIT_MARK
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      out_load;
    emit_sel_e emit_sel;
    logic      push;
    logic      pop;
    logic      set_started;
    logic      clear_text;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  eot;
    logic  started;
    logic  cnt_zero;
    logic  cnt_full;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/msw_ctrl.sv -----
`default_nettype none

module msw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire msw_pkg::sts_t sts_i,
  output msw_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WORK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_MARK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] done_state;

  assign in_stall_o = (state_q != S_IDLE);
  assign done_state = sts_i.eot ? S_MARK : S_IDLE;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.emit_sel    = msw_pkg::EMIT_POP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_WORK;
        end
      end
      S_WORK: begin
        case (sts_i.kind)
          msw_pkg::KIND_WS: begin
            if (!sts_i.started) begin
              state_d = done_state;
            end else if (sts_i.cnt_full) begin
              // overflow: oldest entry goes out, new one takes its slot
              if (sts_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.emit_sel = msw_pkg::EMIT_POP;
                cmd_o.pop      = 1'b1;
                cmd_o.push     = 1'b1;
                state_d        = done_state;
              end
            end else begin
              cmd_o.push = 1'b1;
              state_d    = done_state;
            end
          end
          msw_pkg::KIND_CHAR: begin
            cmd_o.set_started = 1'b1;
            state_d           = S_FLUSH;
          end
          default: begin
            state_d = done_state;
          end
        endcase
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!sts_i.cnt_zero) begin
            cmd_o.emit_sel = msw_pkg::EMIT_POP;
            cmd_o.pop      = 1'b1;
          end else begin
            cmd_o.emit_sel = msw_pkg::EMIT_CHAR;
            state_d        = done_state;
          end
        end
      end
      S_MARK: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.emit_sel   = msw_pkg::EMIT_MARK;
          cmd_o.clear_text = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msw_dp.sv -----
`default_nettype none

module msw_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    text_byte_i,
  input  wire logic          end_of_text_i,
  input  wire msw_pkg::cmd_t cmd_i,
  output msw_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_present_o,
  output logic               run_last_o
);

  localparam int unsigned SumW = msw_pkg::CntW + 1;

  // per-text state
  logic       inside_q, inside_d;
  logic [1:0] nl_run_q, nl_run_d;
  logic       lws_q, lws_d;
  logic       started_q;

  // item latched at accept
  logic [7:0]           b_q, b_d;
  logic [1:0]           code_q, code_d;
  msw_pkg::kind_e       kind_q, kind_d;
  logic                 eot_q;

  // pending queue
  logic [1:0]                 pend_q [msw_pkg::PendDepth];
  logic [msw_pkg::PtrW-1:0]   head_q, head_inc, tail;
  logic [msw_pkg::CntW-1:0]   cnt_q;
  logic [SumW-1:0]            tail_sum;
  logic [7:0]                 pop_byte;

  logic out_valid_q;
  logic [7:0] out_byte_q;
  logic present_q, last_q;

  // collapse stage on the incoming byte
  always_comb begin
    logic [7:0] c;
    logic       keep;
    logic [1:0] nl_inc;
    inside_d = inside_q;
    nl_run_d = nl_run_q;
    lws_d    = lws_q;
    c        = text_byte_i;
    keep     = 1'b0;
    b_d      = c;
    kind_d   = msw_pkg::KIND_NONE;
    nl_inc   = (nl_run_q == 2'd3) ? 2'd3 : nl_run_q + 2'd1;
    if (text_byte_i == msw_pkg::ChLt) begin
      inside_d = 1'b1;
    end else if (text_byte_i == msw_pkg::ChGt) begin
      inside_d = 1'b0;
      c        = msw_pkg::ChSp;
      keep     = 1'b1;
    end else if (!inside_q) begin
      keep = 1'b1;
    end
    if (keep) begin
      if (c == msw_pkg::ChLf) begin
        nl_run_d = nl_inc;
        lws_d    = 1'b0;
        b_d      = msw_pkg::ChLf;
        kind_d   = (nl_inc != 2'd3) ? msw_pkg::KIND_WS : msw_pkg::KIND_NONE;
      end else if (c == msw_pkg::ChSp || c == msw_pkg::ChTab) begin
        nl_run_d = 2'd0;
        b_d      = msw_pkg::ChSp;
        if (!lws_q) begin
          lws_d  = 1'b1;
          kind_d = msw_pkg::KIND_WS;
        end
      end else begin
        nl_run_d = 2'd0;
        lws_d    = 1'b0;
        b_d      = c;
        // CR passes collapse as ordinary but trims as whitespace
        kind_d   = (c == msw_pkg::ChCr) ? msw_pkg::KIND_WS : msw_pkg::KIND_CHAR;
      end
    end
    case (b_d)
      msw_pkg::ChTab: code_d = msw_pkg::WsTab;
      msw_pkg::ChLf:  code_d = msw_pkg::WsLf;
      msw_pkg::ChCr:  code_d = msw_pkg::WsCr;
      default:        code_d = msw_pkg::WsSp;
    endcase
  end

  // queue addressing
  assign head_inc = (head_q == msw_pkg::PtrW'(msw_pkg::PendDepth - 1)) ?
                    '0 : head_q + msw_pkg::PtrW'(1);
  assign tail_sum = SumW'(head_q) + SumW'(cnt_q);
  always_comb begin
    logic [SumW-1:0] wrapped;
    wrapped = (tail_sum >= SumW'(msw_pkg::PendDepth)) ?
              tail_sum - SumW'(msw_pkg::PendDepth) : tail_sum;
    tail    = wrapped[msw_pkg::PtrW-1:0];
  end

  always_comb begin
    case (pend_q[head_q])
      msw_pkg::WsTab: pop_byte = msw_pkg::ChTab;
      msw_pkg::WsLf:  pop_byte = msw_pkg::ChLf;
      msw_pkg::WsCr:  pop_byte = msw_pkg::ChCr;
      default:        pop_byte = msw_pkg::ChSp;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_q[tail] <= code_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      nl_run_q  <= 2'd0;
      lws_q     <= 1'b0;
      started_q <= 1'b0;
      head_q    <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.clear_text) begin
      inside_q  <= 1'b0;
      nl_run_q  <= 2'd0;
      lws_q     <= 1'b0;
      started_q <= 1'b0;
      head_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        inside_q <= inside_d;
        nl_run_q <= nl_run_d;
        lws_q    <= lws_d;
      end
      if (cmd_i.set_started) begin
        started_q <= 1'b1;
      end
      if (cmd_i.pop) begin
        head_q <= head_inc;
      end
      if (cmd_i.push && !cmd_i.pop) begin
        cnt_q <= cnt_q + msw_pkg::CntW'(1);
      end else if (cmd_i.pop && !cmd_i.push) begin
        cnt_q <= cnt_q - msw_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= msw_pkg::KIND_NONE;
      eot_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      kind_q <= kind_d;
      eot_q  <= end_of_text_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      b_q    <= b_d;
      code_q <= code_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.emit_sel)
        msw_pkg::EMIT_CHAR: begin
          out_byte_q <= b_q;
          present_q  <= 1'b1;
          last_q     <= 1'b0;
        end
        msw_pkg::EMIT_MARK: begin
          out_byte_q <= 8'h00;
          present_q  <= 1'b0;
          last_q     <= 1'b1;
        end
        default: begin
          out_byte_q <= pop_byte;
          present_q  <= 1'b1;
          last_q     <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_present_o = present_q;
  assign run_last_o     = last_q;

  assign sts_o.kind     = kind_q;
  assign sts_o.eot      = eot_q;
  assign sts_o.started  = started_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_full = (cnt_q == msw_pkg::CntW'(msw_pkg::PendDepth));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ----- rtl/markup_strip_whitespace_normalizer.sv -----
`default_nettype none

// Channel  Handshake                 Payload                               Beat
// -------  ------------------------  ------------------------------------  ----------------
// in       in_valid_i / in_stall_o   text_byte_i, end_of_text_i            one text byte
// out      out_valid_o / out_stall_i out_byte_o, byte_present_o, run_last_o one result byte
//
// A whitespace or dropped byte passes accept and a trim step; a kept
// character passes accept, a trim step and an emit step. Queued whitespace
// bytes ahead of it are flushed first, and the end marker gets its own step.
// Output stalls freeze the controller only while a new beat waits for the
// output register; a finished beat sitting there does not block the next accept.
// Reset clears text state and queue count; queue entries are read only once written.

module markup_strip_whitespace_normalizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_present_o,
  output logic            run_last_o
);

  msw_pkg::cmd_t cmd;
  msw_pkg::sts_t sts;

  // sequencer: accept, trim decision, queue flush, end marker
  msw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // collapse logic, pending queue, output register
  msw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .run_last_o     (run_last_o)
  );

  // never overwrite a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // a push into a full queue must evict the oldest entry
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push && sts.cnt_full) |-> cmd.pop)
    else $error("push into full queue");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.cnt_zero)
    else $error("pop from empty queue");

  // the end marker carries no byte
  a_marker_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_last_o) |-> !byte_present_o)
    else $error("end marker with byte");

endmodule

`default_nettype wire

// ----- dv/msw_result_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the normalizer, predicts the result beats of every
// accepted text byte and compares them in order with what comes out.
module msw_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       byte_present_i,
  input  logic       run_last_i,
  output int         fail_count_o,
  output int         outstanding_o,
  output int         bytes_in_o,
  output int         results_out_o,
  output int         texts_done_o,
  output int         overflow_pops_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       last;
  } norm_beat_t;

  norm_beat_t normalized_q[$];

  // predicted text state
  logic       in_markup;
  logic [1:0] nl_run;
  logic       last_sp;
  logic       started;
  logic [1:0] ws_fifo [msw_pkg::PendDepth];
  int         ws_count;
  int         ws_head;

  initial begin
    fail_count_o    = 0;
    outstanding_o   = 0;
    bytes_in_o      = 0;
    results_out_o   = 0;
    texts_done_o    = 0;
    overflow_pops_o = 0;
  end

  task automatic clear_text();
    in_markup = 1'b0;
    nl_run    = 2'd0;
    last_sp   = 1'b0;
    started   = 1'b0;
    ws_count  = 0;
    ws_head   = 0;
  endtask

  task automatic release_oldest_ws();
    logic [7:0] ch;
    case (ws_fifo[ws_head])
      msw_pkg::WsSp:  ch = msw_pkg::ChSp;
      msw_pkg::WsTab: ch = msw_pkg::ChTab;
      msw_pkg::WsLf:  ch = msw_pkg::ChLf;
      default:        ch = msw_pkg::ChCr;
    endcase
    ws_head  = (ws_head + 1) % msw_pkg::PendDepth;
    ws_count = ws_count - 1;
    normalized_q.push_back('{ch, 1'b1, 1'b0});
  endtask

  // trailing whitespace waits until a real character shows up
  task automatic trim_push(logic [7:0] b);
    logic       is_ws;
    logic [1:0] code;
    is_ws = 1'b1;
    code  = msw_pkg::WsSp;
    case (b)
      msw_pkg::ChSp:  code = msw_pkg::WsSp;
      msw_pkg::ChTab: code = msw_pkg::WsTab;
      msw_pkg::ChLf:  code = msw_pkg::WsLf;
      msw_pkg::ChCr:  code = msw_pkg::WsCr;
      default:        is_ws = 1'b0;
    endcase
    if (is_ws) begin
      if (started) begin
        if (ws_count >= msw_pkg::PendDepth) begin
          release_oldest_ws();
          overflow_pops_o++;
        end
        ws_fifo[(ws_head + ws_count) % msw_pkg::PendDepth] = code;
        ws_count = ws_count + 1;
      end
    end else begin
      started = 1'b1;
      while (ws_count > 0) release_oldest_ws();
      normalized_q.push_back('{b, 1'b1, 1'b0});
    end
  endtask

  task automatic collapse_push(logic [7:0] c);
    if (c == msw_pkg::ChLf) begin
      if (nl_run < 2'd3) nl_run = nl_run + 2'd1;
      last_sp = 1'b0;
      if (nl_run <= 2'd2) trim_push(msw_pkg::ChLf);
    end else if (c == msw_pkg::ChSp || c == msw_pkg::ChTab) begin
      nl_run = 2'd0;
      if (!last_sp) begin
        last_sp = 1'b1;
        trim_push(msw_pkg::ChSp);
      end
    end else begin
      nl_run  = 2'd0;
      last_sp = 1'b0;
      trim_push(c);
    end
  endtask

  always @(posedge clk_i) begin
    norm_beat_t got;
    norm_beat_t want;
    if (!rst_ni) begin
      clear_text();
      normalized_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        bytes_in_o++;
        if (text_byte_i == msw_pkg::ChLt) begin
          in_markup = 1'b1;
        end else if (text_byte_i == msw_pkg::ChGt) begin
          in_markup = 1'b0;
          collapse_push(msw_pkg::ChSp);
        end else if (!in_markup) begin
          collapse_push(text_byte_i);
        end
        if (end_of_text_i) begin
          // leftover trailing whitespace is dropped
          normalized_q.push_back('{8'h00, 1'b0, 1'b1});
          clear_text();
          texts_done_o++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        results_out_o++;
        got = '{out_byte_i, byte_present_i, run_last_i};
        if (normalized_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected beat byte=%02h present=%0b last=%0b",
                     $realtime, got.ch, got.present, got.last);
          fail_count_o++;
        end else begin
          want = normalized_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch byte=%02h/%02h present=%0b/%0b last=%0b/%0b %s",
                       $realtime, got.ch, want.ch, got.present, want.present,
                       got.last, want.last, "(actual/expected)");
            fail_count_o++;
          end
        end
      end
    end
    outstanding_o <= normalized_q.size();
  end

endmodule

// ----- dv/markup_strip_whitespace_normalizer_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the markup strip / whitespace normalizer.
// All prediction and comparison lives in msw_result_checker.
module markup_strip_whitespace_normalizer_tb;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] text_byte_i   = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_stall_i   = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_present_o;
  logic       run_last_o;

  int fail_count, outstanding, bytes_in, results_out, texts_done, overflow_pops;

  // idling knobs, flipped per text so some texts run back to back
  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  // one-shot request for the receiver to hold off for a long stretch
  bit long_hold_req = 1'b0;

  logic [7:0] text_q[$];
  int         random_bytes;

  always #1 clk_i = ~clk_i;

  markup_strip_whitespace_normalizer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .run_last_o     (run_last_o)
  );

  msw_result_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .byte_present_i  (byte_present_o),
    .run_last_i      (run_last_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .bytes_in_o      (bytes_in),
    .results_out_o   (results_out),
    .texts_done_o    (texts_done),
    .overflow_pops_o (overflow_pops)
  );

  // Send one beat. Called at a falling edge, returns at a falling edge right
  // after the beat was taken. Valid only drops when a gap is actually drawn,
  // so back-to-back beats keep it high without a lower/raise in one step.
  task automatic send_beat(logic [7:0] b, logic last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Whole text from text_q; end_of_text rides on the final byte.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] any_ws();
    case ($urandom_range(0, 3))
      0:       return msw_pkg::ChSp;
      1:       return msw_pkg::ChTab;
      2:       return msw_pkg::ChLf;
      default: return msw_pkg::ChCr;
    endcase
  endfunction

  // Skewed toward whitespace and angle brackets; the rest is any byte value.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(0, 255));
    if (r < 62) return msw_pkg::ChSp;
    if (r < 70) return msw_pkg::ChTab;
    if (r < 82) return msw_pkg::ChLf;
    if (r < 88) return msw_pkg::ChCr;
    if (r < 94) return msw_pkg::ChLt;
    return msw_pkg::ChGt;
  endfunction

  // Random text: mostly well-formed tags and plain bytes, plus long whitespace
  // runs sized around the pending queue depth so overflow and exact trimming
  // both get hit, in the middle of a text and at its tail.
  task automatic build_random_text();
    int len;
    int sel;
    len = $urandom_range(1, 30);
    while (text_q.size() < len) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        repeat ($urandom_range(msw_pkg::PendDepth - 2, msw_pkg::PendDepth + 4))
          text_q.push_back(any_ws());
      end else if (sel < 32) begin
        text_q.push_back(msw_pkg::ChLt);
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(msw_pkg::ChGt);
      end else begin
        text_q.push_back(pick_char());
      end
    end
  endtask

  // Receiver: one stall draw per beat; a long hold-off on request so the
  // block backs up and pushes stall onto the input side.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold          = 300;
        long_hold_req = 1'b0;
      end else begin
        hold = out_gaps_on ? $urandom_range(0, 10) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("markup_strip_whitespace_normalizer_tb: errors");
    $finish;
  end

  initial begin
    int wait_cycles;
    bit hold_done;
    hold_done = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: leading space/CR dropped, nested open bracket, markup body
    // dropped, the closing bracket as a leading space, byte extremes 00/FF,
    // stray closing bracket, tab folding into that space, third newline
    // dropped, CR held as whitespace, trailing whitespace discarded at end.
    text_q = '{msw_pkg::ChSp, msw_pkg::ChCr, msw_pkg::ChLt, msw_pkg::ChLt, 8'h61,
               msw_pkg::ChGt, 8'h00, msw_pkg::ChGt, msw_pkg::ChTab, 8'hFF,
               msw_pkg::ChLf, msw_pkg::ChLf, msw_pkg::ChLf, msw_pkg::ChCr, 8'h5A,
               msw_pkg::ChSp, msw_pkg::ChLf};
    send_text();
    // all-whitespace texts: only the end marker comes out
    text_q = '{msw_pkg::ChSp};
    send_text();
    text_q = '{msw_pkg::ChTab, msw_pkg::ChLf};
    send_text();
    // unterminated markup right up to the end, then a one-byte text
    text_q = '{8'h41, msw_pkg::ChLt, 8'h42};
    send_text();
    text_q = '{8'h51};
    send_text();

    random_bytes = 0;
    while (random_bytes < 420) begin
      in_gaps_on  = ($urandom_range(0, 5) != 0);
      out_gaps_on = ($urandom_range(0, 5) != 0);
      if (!hold_done && random_bytes >= 200) begin
        // sender runs flat out while the receiver sits on its stall
        in_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      build_random_text();
      random_bytes += text_q.size();
      send_text();
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(posedge clk_i);

    $display("run covered %0d text bytes in %0d texts, %0d result beats out,",
             bytes_in, texts_done, results_out);
    $display("with %0d forced releases from a full trailing-whitespace queue",
             overflow_pops);
    if (outstanding != 0)
      $display("%0d predicted beats never came out", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("markup_strip_whitespace_normalizer_tb: clean");
    end else begin
      $display("markup_strip_whitespace_normalizer_tb: errors");
    end
    $finish;
  end

endmodule
